### rtl/core/gfbl_pkg.sv
// ============================================================================
// Grouped free block list package
// Shared types and fixed constants of the grouped free block list.
// ============================================================================
package gfbl_pkg;

   localparam int ID_W   = 10;    // width of a block id
   localparam int CNT_W  = 11;    // width of a block count
   localparam int TALLY_W = 12;   // width of the check tally (saturates)
   localparam int ID_SPACE = 1024;

   typedef enum logic [1:0] {
      MODE_BUILD = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_CHECK = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_BAD_FREE  = 2'd2,
      STAT_BAD_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      CSR_HEAD_BLOCK = 1'b0,
      CSR_SPAN_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_BLD_FILL,
      S_BLD_LINK,
      S_BLD_ZERO,
      S_AL_RD,
      S_AL_EV,
      S_AL_LRD,
      S_AL_LEV,
      S_CP_RD,
      S_CP_EV,
      S_FR_RD,
      S_FR_EV,
      S_FR_HEAD,
      S_CK_RD,
      S_CK_EV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [ID_W-1:0]  allocated_id;
      logic [CNT_W-1:0] unreferenced_count;
   } result_type;

endpackage

### rtl/core/gfbl_if.sv
// ============================================================================
// Grouped free block list channels
// Valid/ready channels for request and response transactions.
// ============================================================================
interface gfbl_req_if
   import gfbl_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [1:0]      mode;
   logic [ID_W-1:0] free_id;

   modport source (output valid, output mode, output free_id, input ready);
   modport sink   (input valid, input mode, input free_id, output ready);
endinterface

interface gfbl_rsp_if
   import gfbl_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [ID_W-1:0]  allocated_id;
   logic [CNT_W-1:0] unreferenced_count;

   modport source (output valid, output status, output allocated_id,
                   output unreferenced_count, input ready);
   modport sink   (input valid, input status, input allocated_id,
                   input unreferenced_count, output ready);
endinterface

### rtl/core/grouped_free_block_list.sv
// ============================================================================
// Grouped free block list
// Block allocator over a store of grouped free lists with build and check.
// ============================================================================
// Operations run one at a time in the sequencer, which reaches the block
// store one slot per access. A finished response waits in an output register.
// Reset clears control state and the configuration registers only; the block
// store is not cleared, so a build must run before any other operation.
module grouped_free_block_list
   import gfbl_pkg::*;
#(
   parameter int NUM_BLOCKS     = 1024,
   parameter int PTRS_PER_BLOCK = 16
) (
   input  logic               clock,
   input  logic               reset,
   gfbl_req_if.sink           req_if,
   gfbl_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [CNT_W-1:0]   csr_wdata
);
   localparam int BLK_W  = $clog2(NUM_BLOCKS > 1 ? NUM_BLOCKS : 2);
   localparam int SLOT_W = $clog2(PTRS_PER_BLOCK);
   localparam int ADDR_W = BLK_W + SLOT_W;

   // Configuration registers.
   logic [ID_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Response holding register.
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic             seq_idle, seq_valid, seq_take;
   result_type       seq_result;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ID_W-1:0]  wr_data, rd_data;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEAD_BLOCK:  head_in  = csr_wdata[ID_W-1:0];
            default:         count_in = csr_wdata;
         endcase
      end
   end

   // The sequencer hands its result over as soon as the holding register is
   // empty or is being emptied in the same cycle.
   assign seq_take = seq_valid && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;
      if (seq_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // A new request is taken whenever the sequencer is idle, even while the
   // previous response still waits to be taken.
   assign req_if.ready = seq_idle;

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.status             = rsp_ff.status;
   assign rsp_if.allocated_id       = rsp_ff.allocated_id;
   assign rsp_if.unreferenced_count = rsp_ff.unreferenced_count;

   gfbl_seq #(
      .NUM_BLOCKS     (NUM_BLOCKS),
      .PTRS_PER_BLOCK (PTRS_PER_BLOCK)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_if.valid && seq_idle),
      .start_mode  (req_if.mode),
      .start_id    (req_if.free_id),
      .head_block  (head_ff),
      .span_count  (count_ff),
      .idle        (seq_idle),
      .res_valid   (seq_valid),
      .res_take    (seq_take),
      .result      (seq_result),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   // Block store: slot s of block b sits at address {b, s}.
   gfbl_ram #(
      .WIDTH (ID_W),
      .DEPTH (2 ** ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
endmodule

### rtl/core/gfbl_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module gfbl_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/gfbl_seq.sv
// ============================================================================
// Grouped free block list sequencer
// Walks the block store one slot at a time for every operation it does not reject.
// ============================================================================
module gfbl_seq
   import gfbl_pkg::*;
#(
   parameter int NUM_BLOCKS     = 1024,
   parameter int PTRS_PER_BLOCK = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          start_mode,
   input  logic [ID_W-1:0]     start_id,
   input  logic [ID_W-1:0]     head_block,
   input  logic [CNT_W-1:0]    span_count,
   output logic                idle,
   output logic                res_valid,
   input  logic                res_take,
   output result_type          result,
   output logic                wr_en,
   output logic [($clog2(NUM_BLOCKS > 1 ? NUM_BLOCKS : 2) +
                  $clog2(PTRS_PER_BLOCK))-1:0] wr_addr,
   output logic [ID_W-1:0]     wr_data,
   output logic [($clog2(NUM_BLOCKS > 1 ? NUM_BLOCKS : 2) +
                  $clog2(PTRS_PER_BLOCK))-1:0] rd_addr,
   input  logic [ID_W-1:0]     rd_data
);
   localparam int BLK_W  = $clog2(NUM_BLOCKS > 1 ? NUM_BLOCKS : 2);
   localparam int SLOT_W = $clog2(PTRS_PER_BLOCK);
   localparam int SEEN_W = $clog2(NUM_BLOCKS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PTRS_PER_BLOCK - 1);
   localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(2048);

   state_type          state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [ID_W-1:0]    cur_ff, cur_in;
   logic [ID_W-1:0]    last_ff, last_in;
   logic [ID_W-1:0]    link_ff, link_in;
   logic [ID_W-1:0]    src_ff, src_in;
   logic [ID_W-1:0]    dst_ff, dst_in;
   logic [TALLY_W-1:0] tally_ff, tally_in, tally_nx;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   result_type         res_ff, res_in;

   logic [ID_W-1:0]    rd_blk, wr_blk;
   logic [SLOT_W-1:0]  wr_slot;
   logic               wr_req;
   logic [ID_W-1:0]    data;
   logic [TALLY_W-1:0] range_end;
   logic               bad_range;

   function automatic logic blk_ok(input logic [ID_W-1:0] blk);
      return 32'(blk) < NUM_BLOCKS;
   endfunction

   assign range_end = TALLY_W'(head_block) + TALLY_W'(span_count);
   assign bad_range = (span_count == '0) || (32'(range_end) > NUM_BLOCKS) ||
                      (range_end > TALLY_W'(ID_SPACE));

   // A block beyond the store reads as all zero slots.
   assign data    = blk_ok(rd_blk) ? rd_data : '0;
   assign rd_addr = {BLK_W'(rd_blk), slot_ff};
   assign wr_addr = {BLK_W'(wr_blk), wr_slot};
   assign wr_en   = wr_req && blk_ok(wr_blk);

   always_comb begin
      unique case (state_ff)
         S_CP_RD, S_CP_EV: rd_blk = src_ff;
         S_CK_RD, S_CK_EV: rd_blk = cur_ff;
         default:          rd_blk = head_block;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (mode_type'(start_mode))
                  MODE_BUILD: state_in = bad_range ? S_DONE : S_BLD_FILL;
                  MODE_ALLOC: state_in = S_AL_RD;
                  MODE_FREE:  state_in = (start_id == '0 || !blk_ok(start_id)) ?
                                         S_DONE : S_FR_RD;
                  default:    state_in = S_CK_RD;
               endcase
            end
         end
         S_BLD_FILL: begin
            if (cur_ff == last_ff) begin
               state_in = S_BLD_ZERO;
            end else if (slot_ff == SLOT_W'(1)) begin
               state_in = S_BLD_LINK;
            end
         end
         S_BLD_LINK: state_in = (cur_ff < last_ff) ? S_BLD_FILL : S_DONE;
         S_BLD_ZERO: if (slot_ff == '0) state_in = S_DONE;
         S_AL_RD:    state_in = S_AL_EV;
         S_AL_EV: begin
            if (data != '0) begin
               state_in = S_DONE;
            end else if (slot_ff == SLOT_W'(1)) begin
               state_in = S_AL_LRD;
            end else begin
               state_in = S_AL_RD;
            end
         end
         S_AL_LRD:   state_in = S_AL_LEV;
         S_AL_LEV:   state_in = (data == '0) ? S_DONE : S_CP_RD;
         S_CP_RD:    state_in = S_CP_EV;
         S_CP_EV: begin
            if (slot_ff != LAST_SLOT) begin
               state_in = S_CP_RD;
            end else if (mode_ff == MODE_FREE) begin
               state_in = S_FR_HEAD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FR_RD:    state_in = S_FR_EV;
         S_FR_EV: begin
            if (data == '0) begin
               state_in = S_DONE;
            end else if (slot_ff == LAST_SLOT) begin
               state_in = S_CP_RD;
            end else begin
               state_in = S_FR_RD;
            end
         end
         S_FR_HEAD:  if (slot_ff == LAST_SLOT) state_in = S_DONE;
         S_CK_RD:    state_in = S_CK_EV;
         S_CK_EV: begin
            if (slot_ff != LAST_SLOT) begin
               state_in = S_CK_RD;
            end else if (link_ff != '0 && 32'(seen_ff) + 1 < NUM_BLOCKS) begin
               state_in = S_CK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE:     if (res_take) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and store accesses.
   always_comb begin
      mode_in  = mode_ff;
      id_in    = id_ff;
      slot_in  = slot_ff;
      cur_in   = cur_ff;
      last_in  = last_ff;
      link_in  = link_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      tally_in = tally_ff;
      seen_in  = seen_ff;
      res_in   = res_ff;
      wr_req   = 1'b0;
      wr_blk   = head_block;
      wr_slot  = slot_ff;
      wr_data  = '0;
      tally_nx = tally_ff;
      if (data != '0 && tally_ff != TALLY_MAX) begin
         tally_nx = tally_ff + TALLY_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = start_mode;
               id_in    = start_id;
               res_in   = '0;
               cur_in   = head_block;
               last_in  = ID_W'(range_end - TALLY_W'(1));
               tally_in = '0;
               seen_in  = '0;
               unique case (mode_type'(start_mode))
                  MODE_BUILD: begin
                     slot_in = LAST_SLOT;
                     if (bad_range) res_in.status = STAT_BAD_RANGE;
                  end
                  MODE_ALLOC: slot_in = LAST_SLOT;
                  MODE_FREE: begin
                     slot_in = SLOT_W'(1);
                     if (start_id == '0 || !blk_ok(start_id)) begin
                        res_in.status = STAT_BAD_FREE;
                     end
                  end
                  default: slot_in = '0;
               endcase
            end
         end
         S_BLD_FILL: begin
            if (cur_ff != last_ff) begin
               wr_req  = 1'b1;
               wr_blk  = cur_ff;
               wr_data = last_ff;
               last_in = last_ff - ID_W'(1);
               if (slot_ff != SLOT_W'(1)) slot_in = slot_ff - SLOT_W'(1);
            end
         end
         S_BLD_LINK: begin
            wr_req  = 1'b1;
            wr_blk  = cur_ff;
            wr_slot = '0;
            if (cur_ff < last_ff) begin
               wr_data = cur_ff + ID_W'(1);
               cur_in  = cur_ff + ID_W'(1);
               slot_in = LAST_SLOT;
            end
         end
         S_BLD_ZERO: begin
            wr_req = 1'b1;
            wr_blk = cur_ff;
            if (slot_ff != '0) slot_in = slot_ff - SLOT_W'(1);
         end
         S_AL_EV: begin
            if (data != '0) begin
               res_in.allocated_id = data;
               wr_req = 1'b1;
            end else if (slot_ff == SLOT_W'(1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff - SLOT_W'(1);
            end
         end
         S_AL_LEV: begin
            if (data == '0) begin
               res_in.status = STAT_EMPTY;
            end else begin
               res_in.allocated_id = data;
               src_in  = data;
               dst_in  = head_block;
               slot_in = '0;
            end
         end
         S_CP_EV: begin
            wr_req  = 1'b1;
            wr_blk  = dst_ff;
            wr_data = data;
            slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
         end
         S_FR_EV: begin
            if (data == '0) begin
               wr_req  = 1'b1;
               wr_data = id_ff;
            end else if (slot_ff == LAST_SLOT) begin
               src_in  = head_block;
               dst_in  = id_ff;
               slot_in = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         S_FR_HEAD: begin
            wr_req  = 1'b1;
            wr_data = (slot_ff == '0) ? id_ff : '0;
            if (slot_ff != LAST_SLOT) slot_in = slot_ff + SLOT_W'(1);
         end
         S_CK_EV: begin
            tally_in = tally_nx;
            if (slot_ff == '0) link_in = data;
            if (slot_ff != LAST_SLOT) begin
               slot_in = slot_ff + SLOT_W'(1);
            end else begin
               seen_in = seen_ff + SEEN_W'(1);
               slot_in = '0;
               cur_in  = link_ff;
               if (tally_nx >= TALLY_W'(span_count)) begin
                  res_in.unreferenced_count = '0;
               end else begin
                  res_in.unreferenced_count =
                     CNT_W'(TALLY_W'(span_count) - tally_nx);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff  <= mode_in;
      id_ff    <= id_in;
      slot_ff  <= slot_in;
      cur_ff   <= cur_in;
      last_ff  <= last_in;
      link_ff  <= link_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      tally_ff <= tally_in;
      seen_ff  <= seen_in;
      res_ff   <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign result    = res_ff;

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (idle && start) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after a request");
   a_empty_no_id: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ff.status == STAT_EMPTY) |-> (res_ff.allocated_id == '0))
      else $error("empty list reported with an id");
   a_unref_check_only: assert property (@(posedge clock) disable iff (reset)
      (res_valid && mode_ff != MODE_CHECK) |-> (res_ff.unreferenced_count == '0))
      else $error("unreferenced count outside check");
   a_build_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLD_FILL || state_ff == S_BLD_LINK || state_ff == S_BLD_ZERO)
      |-> (cur_ff <= last_ff))
      else $error("build walked past the end of the range");
endmodule

### tb/gfbl_checker.sv
// ============================================================================
// Grouped free block list checker
// Mirrors the block store and registers, predicts each response, compares.
// ============================================================================
module gfbl_checker
   import gfbl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   gfbl_req_if              req,
   gfbl_rsp_if              rsp,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CNT_W-1:0] csr_wdata,
   output int               fail_count,
   output int               outstanding
);

   localparam int NBLK = 1024;
   localparam int NPTR = 16;

   typedef logic [ID_W-1:0] slot_row_t [NPTR];

   logic [ID_W-1:0]  store_mirror [NBLK][NPTR];
   logic [ID_W-1:0]  head_reg;
   logic [CNT_W-1:0] count_reg;
   result_type       expected_rsp [$];

   function automatic result_type compute_response(mode_type m, logic [ID_W-1:0] id);
      result_type r;
      slot_row_t  row;
      int         cur;
      int         last;
      int         i;
      int         seen;
      int         tally;
      logic [ID_W-1:0] got;
      r = '0;
      case (m)
         MODE_BUILD: begin
            if (count_reg == 0 || int'(head_reg) + int'(count_reg) > NBLK) begin
               r.status = STAT_BAD_RANGE;
            end else begin
               cur  = int'(head_reg);
               last = int'(head_reg) + int'(count_reg) - 1;
               while (cur <= last) begin
                  for (i = NPTR - 1; i > 0; i--) begin
                     if (cur == last) break;
                     row[i] = last[ID_W-1:0];
                     last--;
                  end
                  if (cur < last) begin
                     row[0] = ID_W'(cur + 1);
                  end else begin
                     for (; i >= 0; i--) row[i] = '0;
                  end
                  store_mirror[cur] = row;
                  cur++;
               end
               r.status = STAT_OK;
            end
         end
         MODE_ALLOC: begin
            row = store_mirror[head_reg];
            got = '0;
            for (i = NPTR - 1; i > 0; i--) begin
               if (row[i] != 0) begin
                  got = row[i];
                  row[i] = '0;
                  store_mirror[head_reg] = row;
                  break;
               end
            end
            // An empty head pulls in the whole linked block.
            if (got == 0 && row[0] != 0) begin
               got = row[0];
               store_mirror[head_reg] = store_mirror[got];
            end
            r.allocated_id = got;
            r.status = (got == 0) ? STAT_EMPTY : STAT_OK;
         end
         MODE_FREE: begin
            if (id == 0) begin
               r.status = STAT_BAD_FREE;
            end else begin
               row = store_mirror[head_reg];
               for (i = 1; i < NPTR; i++) begin
                  if (row[i] == 0) break;
               end
               if (i < NPTR) begin
                  row[i] = id;
                  store_mirror[head_reg] = row;
               end else begin
                  // A full head spills into the freed block, which becomes the link.
                  store_mirror[id] = row;
                  for (i = 1; i < NPTR; i++) row[i] = '0;
                  row[0] = id;
                  store_mirror[head_reg] = row;
               end
               r.status = STAT_OK;
            end
         end
         default: begin
            cur   = int'(head_reg);
            seen  = 0;
            tally = 0;
            forever begin
               row = store_mirror[cur];
               for (i = 0; i < NPTR; i++) if (row[i] != 0) tally++;
               seen++;
               if (row[0] != 0 && seen < NBLK) cur = int'(row[0]);
               else break;
            end
            r.unreferenced_count = (tally >= count_reg) ? '0 : CNT_W'(count_reg - tally);
         end
      endcase
      return r;
   endfunction

   assign outstanding = expected_rsp.size();

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         head_reg   <= '0;
         count_reg  <= '0;
         fail_count <= 0;
         expected_rsp.delete();
      end else begin
         if (req.valid && req.ready)
            expected_rsp.push_back(compute_response(mode_type'(req.mode), req.free_id));
         if (rsp.valid && rsp.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response st=%0d id=%0d unref=%0d", $time,
                        rsp.status, rsp.allocated_id, rsp.unreferenced_count);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.status !== want.status || rsp.allocated_id !== want.allocated_id ||
                   rsp.unreferenced_count !== want.unreferenced_count) begin
                  $display("%0t: mismatch expected st=%0d id=%0d unref=%0d, got st=%0d id=%0d unref=%0d",
                           $time, want.status, want.allocated_id, want.unreferenced_count,
                           rsp.status, rsp.allocated_id, rsp.unreferenced_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_HEAD_BLOCK) head_reg <= csr_wdata[ID_W-1:0];
            else count_reg <= csr_wdata;
         end
      end
   end

endmodule

### tb/tb_top.sv
// ============================================================================
// Grouped free block list testbench
// Builds free lists over many block ranges, then allocates, frees and checks
// them with random gaps on both channels; a checker predicts every response.
// ============================================================================
module tb_top;
   import gfbl_pkg::*;

   localparam int CYCLE_LIMIT = 100000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = CSR_HEAD_BLOCK;
   logic [CNT_W-1:0] csr_wdata = '0;
   int               fail_count;
   int               outstanding;
   int               cycle_count = 0;
   int               issued = 0;
   bit               quiet = 1'b0;   // when set, neither side inserts idle cycles
   int               stall_left = 0;

   gfbl_req_if req_bus ();
   gfbl_rsp_if rsp_bus ();

   always #5 clock = ~clock;

   grouped_free_block_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gfbl_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // The watchdog ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The response side stalls in short random bursts unless the run is quiet.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_bus.ready <= !reset;
         stall_left    <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 3);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Sends one request transaction, with an occasional idle burst ahead of it.
   task automatic send_request(mode_type m, logic [ID_W-1:0] id);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= m;
      req_bus.free_id <= id;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      issued++;
   endtask

   // Registers change only once every response is back and the block is idle.
   task automatic write_register(csr_index_type idx, logic [CNT_W-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // A new head is only ever used after a build that covers it, so no
   // transaction reads a block that was never written.
   task automatic build_range(logic [ID_W-1:0] head, int count);
      write_register(CSR_HEAD_BLOCK, CNT_W'(head));
      write_register(CSR_SPAN_COUNT, CNT_W'(count));
      send_request(MODE_BUILD, '0);
   endtask

   task automatic random_operation();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 42)      send_request(MODE_ALLOC, ID_W'($urandom));
      else if (pick < 80) send_request(MODE_FREE, ($urandom_range(0, 15) == 0) ?
                                       '0 : ID_W'($urandom_range(1, 1023)));
      else if (pick < 92) send_request(MODE_CHECK, ID_W'($urandom));
      else                send_request(MODE_BUILD, ID_W'($urandom));
   endtask

   initial begin
      int head;
      int count;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_BUILD;
      req_bus.free_id = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: a small list drained through its link, frees up to an
      // overflow of the head, the head freed into itself, and a bad free.
      build_range(10'd1, 40);
      send_request(MODE_CHECK, '0);
      repeat (17) send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, '0);
      send_request(MODE_FREE, 10'd1023);
      repeat (15) send_request(MODE_FREE, ID_W'($urandom_range(2, 1022)));
      send_request(MODE_FREE, 10'd1);
      send_request(MODE_CHECK, '0);
      send_request(MODE_ALLOC, '0);

      // Range extremes: empty count, overflowing range, last block, full space.
      build_range(10'd5, 0);
      build_range(10'd1000, 100);
      build_range(10'd1023, 1);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_CHECK, '0);
      build_range(10'd0, 1024);
      send_request(MODE_CHECK, '0);
      send_request(MODE_ALLOC, '0);

      // Random part: mostly short ranges, now and then a long one.
      while (issued < 900) begin
         if (issued > 800) quiet = 1'b1;
         head  = $urandom_range(0, 1023);
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024 - head)
                                             : $urandom_range(1, 60);
         if (count > 1024 - head) count = 1024 - head;
         build_range(ID_W'(head), count);
         if ($urandom_range(0, 7) == 0) begin
            // A rejected build leaves the built list untouched.
            write_register(CSR_SPAN_COUNT, (head == 0) ? CNT_W'(0) : CNT_W'(1024));
            send_request(MODE_BUILD, '0);
         end
         repeat ($urandom_range(10, 40)) random_operation();
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/gfbl_pkg.sv
rtl/core/gfbl_if.sv
rtl/core/gfbl_ram.sv
rtl/core/gfbl_seq.sv
rtl/core/grouped_free_block_list.sv
tb/gfbl_checker.sv
tb/tb_top.sv
